[rtl/matrix_key_debounce_encoder_assert.svh]
// Assertion macros shared by the keypad debounce encoder RTL.
`ifndef MATRIX_KEY_DEBOUNCE_ENCODER_ASSERT_SVH
`define MATRIX_KEY_DEBOUNCE_ENCODER_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define MKDE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MKDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mkde_pkg.sv]
// Package: shared types, constants and the key code remap for the keypad encoder.
package mkde_pkg;

    localparam int KEY_FLAG_BITS = 9;
    localparam int LIMIT_BITS    = 8;
    localparam int CODE_BITS     = 8;
    localparam int HOLD_BITS     = 4;
    localparam int HOLD_CAP      = 15;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 8'd8;
    localparam logic [CODE_BITS-1:0]  CODE_KEEP_MASK = 8'h17;

    // Per-lane status handed to the merge stage
    typedef struct packed {
        logic qual;   // pressed and at or past the debounce limit
        logic clr;    // released while holding its press flag
    } lane_stat_t;

    // Remap press flags into the 8-bit key code
    function automatic logic [CODE_BITS-1:0] encode_code(input logic [KEY_FLAG_BITS-1:0] pf);
        logic [CODE_BITS-1:0] code;
        code = pf[CODE_BITS-1:0] & CODE_KEEP_MASK;
        if (pf[3]) begin
            code[6] = 1'b1;
            code[3] = 1'b0;
        end
        if (pf[6]) begin
            code[3] = 1'b1;
            code[6] = 1'b0;
        end
        if (pf[5]) begin
            code[7] = 1'b1;
            code[5] = 1'b0;
        end
        if (pf[7]) begin
            code[5] = 1'b1;
            code[7] = 1'b0;
        end
        return code;
    endfunction

endpackage

[rtl/mkde_lane.sv]
// One key lane: debounce counter, press flag and sticky release flag.
module mkde_lane
    import mkde_pkg::*;
#(
    parameter int COUNTER_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic                    key_down,
    input  logic [COUNTER_BITS-1:0] limit,
    input  logic                    grant,
    output lane_stat_t              stat,
    output logic                    press_flag,
    output logic                    release_flag
);

    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic                    press_reg, press_next;
    logic                    release_reg, release_next;
    logic                    below;

    // Status toward the merge stage
    assign below     = cnt_reg < limit;
    assign stat.qual = key_down && !below;
    assign stat.clr  = !key_down && press_reg;

    // Next-state for counter and flags
    always_comb begin
        cnt_next     = cnt_reg;
        press_next   = press_reg;
        release_next = release_reg;
        if (step_en) begin
            if (key_down) begin
                if (below) begin
                    cnt_next = cnt_reg + 1'b1;
                end else if (grant) begin
                    press_next = 1'b1;
                end
            end else begin
                cnt_next   = '0;
                press_next = 1'b0;
                if (press_reg) begin
                    release_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            press_reg   <= 1'b0;
            release_reg <= 1'b1;
        end else begin
            cnt_reg     <= cnt_next;
            press_reg   <= press_next;
            release_reg <= release_next;
        end
    end

    assign press_flag   = press_reg;
    assign release_flag = release_reg;

endmodule

[rtl/mkde_merge.sv]
// Merge stage: row-major hold-count chain across lanes, grants the single press flag.
module mkde_merge
    import mkde_pkg::*;
#(
    parameter int LANES    = 9,
    parameter int LOCK_MAX = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  lane_stat_t           stat [LANES],
    output logic [LANES-1:0]     grant,
    output logic [HOLD_BITS-1:0] hold_count
);

    localparam logic [HOLD_BITS-1:0] LockMaxC = HOLD_BITS'(LOCK_MAX);

    logic [HOLD_BITS-1:0] lock_reg, lock_next;
    logic [HOLD_BITS-1:0] lk;

    // Walk lanes in scan order; a qualified key bumps, a released flagged key clears
    always_comb begin
        lk = lock_reg;
        for (int n = 0; n < LANES; n++) begin
            grant[n] = stat[n].qual && (lk == '0);
            if (stat[n].qual && (lk < LockMaxC)) begin
                lk = lk + 1'b1;
            end else if (stat[n].clr) begin
                lk = '0;
            end
        end
        lock_next = step_en ? lk : lock_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg <= '0;
        end else begin
            lock_reg <= lock_next;
        end
    end

    assign hold_count = lock_reg;

endmodule

[rtl/matrix_key_debounce_encoder.sv]
// Top level: keypad matrix debounce encoder with request channels and config write port.
// One scan request is taken per clock when the result slot is free or being drained;
// all keys update together in a lane array, and the shared hold count runs through a
// short chain over the (at most nine) active lanes in the same cycle. The result of a
// request is valid the cycle after acceptance and stays until taken; a new request is
// accepted in the same cycle the previous result is taken, so the sustained rate is one
// request per clock. The debounce limit register resets to 8 and accepts a write every
// cycle (cfg_ready is always high); write it only while no request is in flight.
`include "matrix_key_debounce_encoder_assert.svh"

module matrix_key_debounce_encoder
    import mkde_pkg::*;
#(
    parameter int ROWS         = 3,
    parameter int COLS         = 3,
    parameter int COUNTER_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIMIT_BITS-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [KEY_FLAG_BITS-1:0] s_key_levels,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [KEY_FLAG_BITS-1:0] m_pressed_flags,
    output logic [KEY_FLAG_BITS-1:0] m_released_flags,
    output logic [CODE_BITS-1:0]     m_key_code,
    output logic [HOLD_BITS-1:0]     m_hold_count
);

    localparam int KEYS     = ROWS * COLS;
    localparam int ACTIVE   = (KEYS < KEY_FLAG_BITS) ? KEYS : KEY_FLAG_BITS;
    localparam int LOCK_MAX = (KEYS < HOLD_CAP) ? KEYS : HOLD_CAP;
    localparam int LIM_W    = (COUNTER_BITS > LIMIT_BITS) ? COUNTER_BITS : LIMIT_BITS;
    localparam logic [LIM_W-1:0] CNT_MAX_W = LIM_W'((1 << COUNTER_BITS) - 1);

    logic [LIMIT_BITS-1:0]    limit_reg;
    logic                     m_valid_reg, m_valid_next;
    logic                     step_en;
    logic [LIM_W-1:0]         limit_ext, limit_eff;
    logic [COUNTER_BITS-1:0]  lane_limit;
    lane_stat_t               stat [ACTIVE];
    logic [ACTIVE-1:0]        grant;
    logic [KEY_FLAG_BITS-1:0] press_vec, release_vec;
    logic [HOLD_BITS-1:0]     hold_count;

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Clamp the limit to the counter range
    assign limit_ext  = LIM_W'(limit_reg);
    assign limit_eff  = (limit_ext < CNT_MAX_W) ? limit_ext : CNT_MAX_W;
    assign lane_limit = limit_eff[COUNTER_BITS-1:0];

    // Request handshake; state registers double as the result slot
    assign s_ready = !m_valid_reg || m_ready;
    assign step_en = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Key lanes; flag bits past the key count read zero
    for (genvar i = 0; i < KEY_FLAG_BITS; i++) begin : g_key
        if (i < ACTIVE) begin : g_lane
            mkde_lane #(
                .COUNTER_BITS(COUNTER_BITS)
            ) u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .step_en     (step_en),
                .key_down    (s_key_levels[i]),
                .limit       (lane_limit),
                .grant       (grant[i]),
                .stat        (stat[i]),
                .press_flag  (press_vec[i]),
                .release_flag(release_vec[i])
            );
        end else begin : g_none
            assign press_vec[i]   = 1'b0;
            assign release_vec[i] = 1'b0;
        end
    end

    // Hold-count chain and press grant
    mkde_merge #(
        .LANES   (ACTIVE),
        .LOCK_MAX(LOCK_MAX)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .stat      (stat),
        .grant     (grant),
        .hold_count(hold_count)
    );

    // Result fields
    assign m_valid          = m_valid_reg;
    assign m_pressed_flags  = press_vec;
    assign m_released_flags = release_vec;
    assign m_key_code       = encode_code(press_vec);
    assign m_hold_count     = hold_count;

    // Checks
    `MKDE_ASSERT_ALWAYS(a_flag_tracks_hold, ($onehot0(press_vec) && ((hold_count != '0) == (press_vec != '0))), "press flag and hold count disagree")
    `MKDE_ASSERT_ALWAYS(a_hold_cap, (hold_count <= HOLD_BITS'(LOCK_MAX)), "hold count past its cap")
    `MKDE_ASSERT_NEXT(a_result_after_accept, step_en, (m_valid && (m_hold_count == $past(hold_count) || $past(step_en))), "accepted request left no result")

endmodule

[test/matrix_key_debounce_encoder_checker.sv]
// Scan checker: predicts each keypad scan result and compares it with the block's output.
module mkde_scan_checker
    import mkde_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [LIMIT_BITS-1:0]    cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [KEY_FLAG_BITS-1:0] s_key_levels,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [KEY_FLAG_BITS-1:0] m_pressed_flags,
    input  logic [KEY_FLAG_BITS-1:0] m_released_flags,
    input  logic [CODE_BITS-1:0]     m_key_code,
    input  logic [HOLD_BITS-1:0]     m_hold_count,
    output int                       pending,
    output int                       mismatches
);

    localparam int KEY_COUNT  = 9;
    localparam int HOLD_LIMIT = (KEY_COUNT < HOLD_CAP) ? KEY_COUNT : HOLD_CAP;

    typedef struct packed {
        logic [KEY_FLAG_BITS-1:0] pressed;
        logic [KEY_FLAG_BITS-1:0] released;
        logic [CODE_BITS-1:0]     code;
        logic [HOLD_BITS-1:0]     hold;
    } scan_result_t;

    // Shadow of the block's key state
    logic [LIMIT_BITS-1:0]    debounce_cnt [KEY_COUNT];
    logic [KEY_FLAG_BITS-1:0] pressed_now;
    logic [KEY_FLAG_BITS-1:0] released_seen;
    logic [HOLD_BITS-1:0]     hold_cnt;
    logic [LIMIT_BITS-1:0]    limit_reg;

    scan_result_t scan_results_due [$];
    scan_result_t due;

    // One scan tick: keys in row-major order, hold count chained through them
    function automatic scan_result_t advance_scan(input logic [KEY_FLAG_BITS-1:0] levels);
        scan_result_t r;
        logic         was_flagged;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (levels[k]) begin
                if (debounce_cnt[k] < limit_reg) begin
                    debounce_cnt[k] = debounce_cnt[k] + 1'b1;
                end else if (hold_cnt < HOLD_LIMIT) begin
                    hold_cnt = hold_cnt + 1'b1;
                    // only the key that brings the count to one is flagged
                    if (hold_cnt == 1) pressed_now[k] = 1'b1;
                end
            end else begin
                was_flagged     = pressed_now[k];
                debounce_cnt[k] = '0;
                pressed_now[k]  = 1'b0;
                if (was_flagged) begin
                    released_seen[k] = 1'b1;
                    hold_cnt         = '0;
                end
            end
        end
        r.pressed  = pressed_now;
        r.released = released_seen;
        // bits 0,1,2,4 direct; 3 <- flag 6; 6 <- flag 3 unless 6; 5 <- flag 7; 7 <- flag 5 unless 7
        r.code = {pressed_now[5] & ~pressed_now[7], pressed_now[3] & ~pressed_now[6],
                  pressed_now[7], pressed_now[4], pressed_now[6], pressed_now[2:0]};
        r.hold = hold_cnt;
        return r;
    endfunction

    task automatic report_field(input string field, input logic [KEY_FLAG_BITS-1:0] want,
                                input logic [KEY_FLAG_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Track config writes and requests, compare results in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_COUNT; k++) debounce_cnt[k] = '0;
            pressed_now   = '0;
            released_seen = '1;
            hold_cnt      = '0;
            limit_reg     = LIMIT_RESET;
            scan_results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (scan_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h %h",
                             $time, m_pressed_flags, m_released_flags, m_key_code,
                             m_hold_count);
                    mismatches++;
                end else begin
                    due = scan_results_due.pop_front();
                    report_field("pressed_flags", due.pressed, m_pressed_flags);
                    report_field("released_flags", due.released, m_released_flags);
                    report_field("key_code", 9'(due.code), 9'(m_key_code));
                    report_field("hold_count", 9'(due.hold), 9'(m_hold_count));
                end
            end
            if (cfg_valid && cfg_ready) limit_reg = cfg_data;
            if (s_valid && s_ready) scan_results_due.push_back(advance_scan(s_key_levels));
        end
        pending = scan_results_due.size();
    end

endmodule

[test/matrix_key_debounce_encoder_test.sv]
// Testbench top: drives keypad scan requests and limit writes, gives the verdict.
module matrix_key_debounce_encoder_test;
    import mkde_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                     aclk         = 1'b0;
    logic                     aresetn      = 1'b0;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [LIMIT_BITS-1:0]    cfg_data     = '0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [KEY_FLAG_BITS-1:0] s_key_levels = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic [KEY_FLAG_BITS-1:0] m_pressed_flags;
    logic [KEY_FLAG_BITS-1:0] m_released_flags;
    logic [CODE_BITS-1:0]     m_key_code;
    logic [HOLD_BITS-1:0]     m_hold_count;

    int   pending;
    int   mismatches;
    int   cycle_count  = 0;
    int   stall_left   = 0;
    logic sink_steady  = 1'b0;
    logic src_steady   = 1'b0;

    matrix_key_debounce_encoder DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_levels     (s_key_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pressed_flags  (m_pressed_flags),
        .m_released_flags (m_released_flags),
        .m_key_code       (m_key_code),
        .m_hold_count     (m_hold_count)
    );

    mkde_scan_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_levels     (s_key_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pressed_flags  (m_pressed_flags),
        .m_released_flags (m_released_flags),
        .m_key_code       (m_key_code),
        .m_hold_count     (m_hold_count),
        .pending          (pending),
        .mismatches       (mismatches)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (sink_steady || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            stall_left <= pick_gap() - 1;
            m_ready    <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one scan request, wait for it to be taken, maybe idle afterwards
    task automatic send_scan(input logic [KEY_FLAG_BITS-1:0] levels);
        s_valid      <= 1'b1;
        s_key_levels <= levels;
        // ready is sampled ahead of the edge that takes the request
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        if (!src_steady && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
    endtask

    // Hold off until every outstanding result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Press sequences: hold a pattern past the limit with some bounce, then let go
    task automatic run_presses(input int budget, input logic [LIMIT_BITS-1:0] lim);
        int                       sent;
        int                       hold;
        int                       n;
        logic [KEY_FLAG_BITS-1:0] pattern;
        logic [KEY_FLAG_BITS-1:0] still_held;
        logic [KEY_FLAG_BITS-1:0] lv;
        sent       = 0;
        still_held = '0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                // plain noise
                n = $urandom_range(1, 4);
                repeat (n) send_scan(KEY_FLAG_BITS'($urandom));
                sent += n;
            end else begin
                case ($urandom_range(0, 3))
                    0, 1: pattern = KEY_FLAG_BITS'(1) << $urandom_range(0, 8);
                    2: pattern = (KEY_FLAG_BITS'(1) << $urandom_range(0, 8))
                               | (KEY_FLAG_BITS'(1) << $urandom_range(0, 8));
                    default: pattern = KEY_FLAG_BITS'($urandom);
                endcase
                pattern |= still_held;
                hold = int'(lim) + $urandom_range(0, 6);
                // now and then a shorter press, at times too short to qualify
                if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, int'(lim) + 1);
                for (int t = 0; t < hold; t++) begin
                    lv = pattern;
                    if ($urandom_range(0, 11) == 0) lv ^= KEY_FLAG_BITS'(1) << $urandom_range(0, 8);
                    send_scan(lv);
                end
                sent += hold;
                // release all, or keep some keys down into the next press
                if ($urandom_range(0, 1) == 0) still_held = pattern & KEY_FLAG_BITS'($urandom);
                else still_held = '0;
                n = $urandom_range(1, 3);
                repeat (n) send_scan(still_held);
                sent += n;
            end
            if ($urandom_range(0, 59) == 0) drain();
            if ($urandom_range(0, 19) == 0) begin
                src_steady  = ~src_steady;
                sink_steady <= ~sink_steady;
            end
        end
    endtask

    initial begin
        logic [LIMIT_BITS-1:0] phase_limits [6];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limit: all keys at once, hold saturates, first key flagged
        send_scan('0);
        repeat (10) send_scan('1);
        send_scan('0);

        // Limit zero: keys qualify on the first tick, each remapped code bit
        write_limit(8'd0);
        send_scan(9'h008);
        send_scan(9'h000);
        send_scan(9'h040);
        send_scan(9'h000);
        send_scan(9'h020);
        send_scan(9'h000);
        send_scan(9'h080);
        send_scan(9'h000);
        send_scan(9'h100);
        send_scan(9'h000);
        send_scan('1);
        send_scan(9'h000);
        send_scan(9'h010);

        // Raise the limit to its top while key 4 is flagged, then release it
        write_limit(8'd255);
        send_scan(9'h000);
        // key 1 must sit through the full count before it qualifies
        for (int t = 0; t < 260; t++) send_scan(9'h002 | (KEY_FLAG_BITS'($urandom) & 9'h1FC));
        send_scan(9'h000);

        // Random press sequences at several limits
        phase_limits = '{8'd1, 8'd3, 8'd0, LIMIT_BITS'($urandom_range(4, 12)), 8'd2, LIMIT_RESET};
        foreach (phase_limits[p]) begin
            write_limit(phase_limits[p]);
            src_steady  = (p == 2);
            sink_steady <= (p == 2);
            run_presses(200, phase_limits[p]);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[matrix_key_debounce_encoder.f]
+incdir+rtl
rtl/mkde_pkg.sv
rtl/mkde_lane.sv
rtl/mkde_merge.sv
rtl/matrix_key_debounce_encoder.sv
test/matrix_key_debounce_encoder_checker.sv
test/matrix_key_debounce_encoder_test.sv
